### design/md5_hash_engine_defines.svh
// ----------------------------------------------------------------------------
// md5_hash_engine_defines: assertion macros
// concurrent check wrappers that compile away under synthesis
// ----------------------------------------------------------------------------
`ifndef MD5_HASH_ENGINE_DEFINES_SVH
`define MD5_HASH_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define MD5_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// consequent that must hold in the cycle after the antecedent
`define MD5_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MD5_ASSERT(lbl, clk, rstn, prop, msg)
`define MD5_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### design/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// shared types, constants and round tables of the md5 hash engine
// ----------------------------------------------------------------------------
package md5_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PSTART,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } md5_state_e;

  // the four working or chaining words
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_abcd_t;

  // initial chaining values
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // padding constants
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] PAD_LEN_POS = 6'd56;
  localparam logic [3:0] LEN_LO_WORD = 4'd14;
  localparam logic [3:0] LEN_HI_WORD = 4'd15;
  localparam logic [3:0] LAST_WORD   = 4'd15;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [5:0] LAST_BYTE   = 6'd63;

  // round additive constants
  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, indexed by {stage, round mod 4}
  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [31:0] round_const(logic [5:0] r);
    return ROUND_K[r];
  endfunction

  function automatic logic [4:0] rot_amount(logic [5:0] r);
    return ROT_S[{r[5:4], r[1:0]}];
  endfunction

  // message word used by a round
  function automatic logic [3:0] msg_index(logic [5:0] r);
    logic [3:0] i;
    logic [3:0] g;
    i = r[3:0];
    unique case (r[5:4])
      2'd0: g = i;
      2'd1: g = (i << 2) + i + 4'd1;
      2'd2: g = (i << 1) + i + 4'd5;
      2'd3: g = (i << 3) - i;
    endcase
    return g;
  endfunction

endpackage

### design/md5_round.sv
// ----------------------------------------------------------------------------
// md5_round
// shared round unit: one md5 step on the working words per use
// ----------------------------------------------------------------------------
module md5_round (
  input  md5_pkg::md5_abcd_t st_i,
  input  logic [31:0]        w_i,
  input  logic [5:0]         round_i,
  output md5_pkg::md5_abcd_t st_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;

  // boolean function of the stage
  always_comb begin
    unique case (round_i[5:4])
      2'd0: f = st_i.d ^ (st_i.b & (st_i.c ^ st_i.d));
      2'd1: f = st_i.c ^ (st_i.d & (st_i.b ^ st_i.c));
      2'd2: f = st_i.b ^ st_i.c ^ st_i.d;
      2'd3: f = st_i.c ^ (st_i.b | ~st_i.d);
    endcase
  end

  // add, rotate and shift the word set
  always_comb begin
    sum    = st_i.a + f + md5_pkg::round_const(round_i) + w_i;
    dbl    = {sum, sum} << md5_pkg::rot_amount(round_i);
    st_o.a = st_i.d;
    st_o.b = st_i.b + dbl[63:32];
    st_o.c = st_i.b;
    st_o.d = st_i.c;
  end

endmodule

### design/md5_hash_engine.sv
// ----------------------------------------------------------------------------
// md5_hash_engine: byte-serial md5 digest
// byte beats are taken only while idle; the 64th byte of a block starts a
// compression (a load, 64 rounds through the shared round unit, a chain add)
// end of message: a setup state, up to 16 pad word writes per padded block,
// one or two compressions, then four digest beats, with no bytes taken meanwhile
// reset sets the chain words to the initial values and the byte count to zero
// ----------------------------------------------------------------------------
`include "md5_hash_engine_defines.svh"

module md5_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);

  md5_pkg::md5_state_e state_q, state_d;
  md5_pkg::md5_abcd_t  chain_q, chain_d;
  md5_pkg::md5_abcd_t  work_q, work_d;
  md5_pkg::md5_abcd_t  round_st;

  logic [5:0]  round_q, round_d;
  logic [60:0] cnt_q, cnt_d;
  logic [23:0] asm_q, asm_d;
  logic [3:0]  pad_addr_q, pad_addr_d;
  logic        first_q, first_d;
  logic        len_q, len_d;
  logic        pad_more_q, pad_more_d;
  logic        pad_started_q, pad_started_d;
  logic        fin_q, fin_d;
  logic [1:0]  emit_q, emit_d;

  logic [31:0] mem [16];
  logic [31:0] rdata_q;
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_raddr;
  logic [31:0] pad_word;
  logic [31:0] asm_ext;

  logic        in_fire;
  logic        out_fire;
  logic        byte_fire;
  logic        blk_full;
  logic [1:0]  lane;

  // handshakes
  always_comb begin
    in_ready_o  = (state_q == md5_pkg::ST_IDLE);
    out_valid_o = (state_q == md5_pkg::ST_EMIT);
    in_fire     = in_valid_i && in_ready_o;
    out_fire    = out_valid_o && out_ready_i;
    byte_fire   = in_fire && byte_present_i;
    lane        = cnt_q[1:0];
    blk_full    = byte_fire && (cnt_q[5:0] == md5_pkg::LAST_BYTE);
  end

  // digest beat
  always_comb begin
    unique case (emit_q)
      2'd0: digest_word_o = chain_q.a;
      2'd1: digest_word_o = chain_q.b;
      2'd2: digest_word_o = chain_q.c;
      2'd3: digest_word_o = chain_q.d;
    endcase
    word_index_o = emit_q;
    last_word_o  = (emit_q == 2'd3);
  end

  // padding word: kept bytes, marker byte, zeros or bit length
  always_comb begin
    asm_ext  = {8'h00, asm_q};
    pad_word = '0;
    if (first_q) begin
      for (int i = 0; i < 4; i++) begin
        if (2'(i) < lane) begin
          pad_word[i*8 +: 8] = asm_ext[i*8 +: 8];
        end else if (2'(i) == lane) begin
          pad_word[i*8 +: 8] = md5_pkg::PAD_BYTE;
        end
      end
    end else if (len_q && pad_addr_q == md5_pkg::LEN_LO_WORD) begin
      pad_word = {cnt_q[28:0], 3'b000};
    end else if (len_q && pad_addr_q == md5_pkg::LEN_HI_WORD) begin
      pad_word = cnt_q[60:29];
    end
  end

  // buffer port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q[5:2];
    mem_wdata = {data_byte_i, asm_q};
    if (state_q == md5_pkg::ST_IDLE) begin
      mem_we = byte_fire && (lane == 2'd3);
    end else if (state_q == md5_pkg::ST_PAD) begin
      mem_we    = 1'b1;
      mem_waddr = pad_addr_q;
      mem_wdata = pad_word;
    end
    if (state_q == md5_pkg::ST_ROUND) begin
      mem_raddr = md5_pkg::msg_index(round_q + 6'd1);
    end else begin
      mem_raddr = '0;
    end
  end

  // block buffer, one word per entry
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // shared round unit
  md5_round u_round (
    .st_i    (work_q),
    .w_i     (rdata_q),
    .round_i (round_q),
    .st_o    (round_st)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      md5_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (blk_full) begin
            state_d = md5_pkg::ST_LOAD;
          end else if (end_of_message_i) begin
            state_d = md5_pkg::ST_PSTART;
          end
        end
      end
      md5_pkg::ST_PSTART: state_d = md5_pkg::ST_PAD;
      md5_pkg::ST_PAD: begin
        if (pad_addr_q == md5_pkg::LAST_WORD) begin
          state_d = md5_pkg::ST_LOAD;
        end
      end
      md5_pkg::ST_LOAD: state_d = md5_pkg::ST_ROUND;
      md5_pkg::ST_ROUND: begin
        if (round_q == md5_pkg::LAST_ROUND) begin
          state_d = md5_pkg::ST_FINAL;
        end
      end
      md5_pkg::ST_FINAL: begin
        priority if (fin_q) begin
          state_d = md5_pkg::ST_EMIT;
        end else if (pad_more_q && pad_started_q) begin
          state_d = md5_pkg::ST_PAD;
        end else if (pad_more_q) begin
          state_d = md5_pkg::ST_PSTART;
        end else begin
          state_d = md5_pkg::ST_IDLE;
        end
      end
      md5_pkg::ST_EMIT: begin
        if (out_fire && emit_q == 2'd3) begin
          state_d = md5_pkg::ST_IDLE;
        end
      end
      default: state_d = md5_pkg::ST_IDLE;
    endcase
  end

  // datapath and counters
  always_comb begin
    chain_d       = chain_q;
    work_d        = work_q;
    round_d       = round_q;
    cnt_d         = cnt_q;
    asm_d         = asm_q;
    pad_addr_d    = pad_addr_q;
    first_d       = first_q;
    len_d         = len_q;
    pad_more_d    = pad_more_q;
    pad_started_d = pad_started_q;
    fin_d         = fin_q;
    emit_d        = emit_q;
    unique case (state_q)
      md5_pkg::ST_IDLE: begin
        if (in_fire) begin
          pad_more_d    = end_of_message_i;
          pad_started_d = 1'b0;
          fin_d         = 1'b0;
          if (byte_present_i) begin
            cnt_d = cnt_q + 61'd1;
            unique case (lane)
              2'd0: asm_d[7:0]   = data_byte_i;
              2'd1: asm_d[15:8]  = data_byte_i;
              2'd2: asm_d[23:16] = data_byte_i;
              2'd3: asm_d        = asm_q;
            endcase
          end
        end
      end
      md5_pkg::ST_PSTART: begin
        pad_addr_d    = cnt_q[5:2];
        first_d       = 1'b1;
        len_d         = (cnt_q[5:0] < md5_pkg::PAD_LEN_POS);
        pad_started_d = 1'b1;
      end
      md5_pkg::ST_PAD: begin
        first_d    = 1'b0;
        pad_addr_d = pad_addr_q + 4'd1;
        if (pad_addr_q == md5_pkg::LAST_WORD) begin
          fin_d      = len_q;
          pad_more_d = !len_q;
        end
      end
      md5_pkg::ST_LOAD: begin
        work_d  = chain_q;
        round_d = '0;
      end
      md5_pkg::ST_ROUND: begin
        work_d  = round_st;
        round_d = round_q + 6'd1;
      end
      md5_pkg::ST_FINAL: begin
        chain_d.a = chain_q.a + work_q.a;
        chain_d.b = chain_q.b + work_q.b;
        chain_d.c = chain_q.c + work_q.c;
        chain_d.d = chain_q.d + work_q.d;
        // second padded block holds only zeros and the length
        if (pad_more_q && pad_started_q) begin
          pad_addr_d = '0;
          first_d    = 1'b0;
          len_d      = 1'b1;
        end
      end
      md5_pkg::ST_EMIT: begin
        if (out_fire) begin
          emit_d = emit_q + 2'd1;
          if (emit_q == 2'd3) begin
            chain_d.a = md5_pkg::IV_A;
            chain_d.b = md5_pkg::IV_B;
            chain_d.c = md5_pkg::IV_C;
            chain_d.d = md5_pkg::IV_D;
            cnt_d     = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // control and chaining registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= md5_pkg::ST_IDLE;
      chain_q.a     <= md5_pkg::IV_A;
      chain_q.b     <= md5_pkg::IV_B;
      chain_q.c     <= md5_pkg::IV_C;
      chain_q.d     <= md5_pkg::IV_D;
      round_q       <= '0;
      cnt_q         <= '0;
      pad_addr_q    <= '0;
      first_q       <= 1'b0;
      len_q         <= 1'b0;
      pad_more_q    <= 1'b0;
      pad_started_q <= 1'b0;
      fin_q         <= 1'b0;
      emit_q        <= '0;
    end else begin
      state_q       <= state_d;
      chain_q       <= chain_d;
      round_q       <= round_d;
      cnt_q         <= cnt_d;
      pad_addr_q    <= pad_addr_d;
      first_q       <= first_d;
      len_q         <= len_d;
      pad_more_q    <= pad_more_d;
      pad_started_q <= pad_started_d;
      fin_q         <= fin_d;
      emit_q        <= emit_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    asm_q  <= asm_d;
  end

  // checks
  `MD5_ASSERT(a_ready_excl, clk_i, rst_ni, !(in_ready_o && out_valid_o), "input ready while digest pending")
  `MD5_ASSERT_NEXT(a_round_end, clk_i, rst_ni, (state_q == md5_pkg::ST_ROUND && round_q == md5_pkg::LAST_ROUND), (state_q == md5_pkg::ST_FINAL), "round count overrun")
  `MD5_ASSERT_NEXT(a_word_seq, clk_i, rst_ni, (out_valid_o && out_ready_i && !last_word_o), (out_valid_o && word_index_o == $past(word_index_o) + 2'd1), "digest word sequence broken")
  `MD5_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, (out_valid_o && out_ready_i && last_word_o), in_ready_o, "not idle after last digest word")

endmodule

### verif/md5_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_checker: digest predictor and beat comparator
// follows every accepted byte beat with an independent md5 model, queues the
// four digest words due at each end of message and compares every accepted
// digest beat against the oldest queued word, field by field
// ----------------------------------------------------------------------------
module md5_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] digest_word_i,
  input  logic [1:0]  word_index_i,
  input  logic        last_word_i,
  output int          pending_o,
  output int          fail_count_o
);

  // per-round additive constants, floor(abs(sin(i + 1)) * 2^32)
  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // left rotate amounts, four per stage
  localparam int SHIFT_TBL [16] = '{
    7, 12, 17, 22,
    5, 9,  14, 20,
    4, 11, 16, 23,
    6, 10, 15, 21
  };

  // one queued digest beat
  typedef struct {
    logic [31:0] digest;
    logic [1:0]  slot;
    logic        last;
  } digest_beat_t;

  logic [31:0]  chain [4];
  logic [7:0]   blk [64];
  logic [60:0]  byte_cnt;
  digest_beat_t digest_q [$];
  int           fail_count;

  function automatic logic [31:0] rol32(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // back to the initial chaining values for a new message
  function automatic void restart_chain();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    byte_cnt = '0;
  endfunction

  // 64 rounds over the block buffer, folded into the chain
  function automatic void fold_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int          g, st;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int r = 0; r < 64; r++) begin
      st = r / 16;
      case (st)
        0: begin
          f = d ^ (b & (c ^ d));
          g = r;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rol32(a + f + SINE_K[r] + w[g], SHIFT_TBL[st * 4 + r % 4]);
      a = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endfunction

  // take one byte beat; on end of message pad, finish and queue the digest
  function automatic void absorb_beat(logic [7:0] data, logic present, logic eom);
    int          pos;
    logic [63:0] bit_len;
    if (present) begin
      pos = int'(byte_cnt[5:0]);
      blk[pos] = data;
      byte_cnt = byte_cnt + 61'd1;
      if (pos == 63) fold_block();
    end
    if (eom) begin
      pos = int'(byte_cnt[5:0]);
      bit_len = {byte_cnt, 3'b000};
      blk[pos] = 8'h80;
      pos++;
      // no room left for the length: close this block and open another
      if (pos > 56) begin
        while (pos < 64) begin
          blk[pos] = 8'h00;
          pos++;
        end
        fold_block();
        pos = 0;
      end
      while (pos < 56) begin
        blk[pos] = 8'h00;
        pos++;
      end
      for (int k = 0; k < 8; k++) blk[56 + k] = bit_len[8*k +: 8];
      fold_block();
      for (int k = 0; k < 4; k++) begin
        digest_q.push_back('{digest: chain[k], slot: 2'(k), last: (k == 3)});
      end
      restart_chain();
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  // compare one accepted digest beat with the oldest expectation
  task automatic check_digest_beat();
    digest_beat_t exp_beat;
    if (digest_q.size() == 0) begin
      report_mismatch("digest beat with nothing pending", digest_word_i, '0);
    end else begin
      exp_beat = digest_q.pop_front();
      if (digest_word_i !== exp_beat.digest)
        report_mismatch("digest_word", digest_word_i, exp_beat.digest);
      if (word_index_i !== exp_beat.slot)
        report_mismatch("word_index", 32'(word_index_i), 32'(exp_beat.slot));
      if (last_word_i !== exp_beat.last)
        report_mismatch("last_word", 32'(last_word_i), 32'(exp_beat.last));
    end
  endtask

  initial begin
    fail_count = 0;
    pending_o = 0;
    fail_count_o = 0;
  end

  // watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_chain();
      digest_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) absorb_beat(data_byte_i, byte_present_i, end_of_message_i);
      if (out_valid_i && out_ready_i) check_digest_beat();
    end
    pending_o = digest_q.size();
    fail_count_o = fail_count;
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: md5 hash engine testbench
// feeds directed and random messages one byte beat at a time, with random
// gaps on the byte side and random back-pressure on the digest side; the
// checker predicts every digest and the top gives the verdict
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RESET_CYCLES = 8;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int BYTE_TARGET  = 450;
  localparam int MSG_TARGET   = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  int digest_pending;
  int mismatch_count;
  int cycle_count = 0;
  int burst_left  = 0;
  int bytes_sent  = 0;
  int msgs_sent   = 0;
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;

  md5_hash_engine DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .data_byte_i      (data_byte),
    .byte_present_i   (byte_present),
    .end_of_message_i (end_of_message),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .digest_word_o    (digest_word),
    .word_index_o     (word_index),
    .last_word_o      (last_word)
  );

  md5_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .data_byte_i      (data_byte),
    .byte_present_i   (byte_present),
    .end_of_message_i (end_of_message),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .digest_word_i    (digest_word),
    .word_index_i     (word_index),
    .last_word_i      (last_word),
    .pending_o        (digest_pending),
    .fail_count_o     (mismatch_count)
  );

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] run limit reached, %0d digest words outstanding", $time, digest_pending);
      $display("Verification failed");
      $finish;
    end
  end

  // idle length before a byte beat: bursts with no gaps, mostly short, a few long
  function automatic int next_send_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = 40;
      return 0;
    end
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // stall length on the digest side
  function automatic int next_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // offer one byte beat, hold it until accepted; starts and ends at a falling edge
  task automatic push_beat(logic [7:0] data, logic present, logic eom);
    int gap;
    gap = next_send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid       <= 1'b1;
    data_byte      <= data;
    byte_present   <= present;
    end_of_message <= eom;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    if (present) bytes_sent++;
  endtask

  // a message of len random bytes, with the odd empty beat mixed in;
  // the end flag rides on the last byte or on an empty closing beat
  task automatic send_message(int len, bit close_empty);
    bit sep;
    sep = close_empty || (len == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) push_beat(8'($urandom), 1'b0, 1'b0);
      push_beat(8'($urandom), 1'b1, !sep && (i == len - 1));
    end
    if (sep) push_beat(8'($urandom), 1'b0, 1'b1);
    msgs_sent++;
  endtask

  // hold the byte side off until every queued digest word has come back
  task automatic drain_digests();
    in_valid <= 1'b0;
    wait (digest_pending == 0);
    @(negedge clk_i);
  endtask

  // message lengths: short, around the padding boundaries, or mid-sized
  function automatic int pick_length();
    int r;
    int edges [10] = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120};
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 8);
    if (r < 75) return edges[$urandom_range(0, 9)];
    return $urandom_range(9, 70);
  endfunction

  // digest side ready with random stalls, stall-free runs and one long hold
  initial begin
    int stall_n;
    int run_n;
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        stall_n = LONG_HOLD;
      end else begin
        stall_n = next_stall();
      end
      run_n = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12);
      if (stall_n > 0) begin
        out_ready <= 1'b0;
        repeat (stall_n) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      repeat (run_n) @(negedge clk_i);
    end
  end

  // stimulus and verdict
  initial begin
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    data_byte      = '0;
    byte_present   = 1'b0;
    end_of_message = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty beat, empty message, extreme bytes, both ways of closing
    push_beat(8'hA5, 1'b0, 1'b0);
    push_beat(8'h00, 1'b0, 1'b1);
    push_beat(8'h00, 1'b1, 1'b1);
    push_beat(8'hFF, 1'b1, 1'b0);
    push_beat(8'h5A, 1'b0, 1'b1);
    push_beat(8'h61, 1'b1, 1'b0);
    push_beat(8'h62, 1'b1, 1'b0);
    push_beat(8'hC3, 1'b0, 1'b0);
    push_beat(8'h63, 1'b1, 1'b1);
    push_beat(8'h80, 1'b1, 1'b0);
    push_beat(8'h7F, 1'b1, 1'b0);
    push_beat(8'h01, 1'b1, 1'b0);
    push_beat(8'hFE, 1'b1, 1'b1);
    push_beat(8'hFF, 1'b0, 1'b1);
    drain_digests();

    // random messages
    bytes_sent = 0;
    msgs_sent = 0;
    while (bytes_sent < BYTE_TARGET || msgs_sent < MSG_TARGET) begin
      // digest side holds off while short messages keep coming
      if (msgs_sent == 4) begin
        long_hold_req = 1'b1;
        for (int j = 0; j < 4; j++) send_message($urandom_range(0, 6), $urandom_range(0, 1));
      end
      if (msgs_sent == 10) drain_digests();
      send_message(pick_length(), ($urandom_range(0, 3) == 0));
    end

    in_valid <= 1'b0;
    wait (digest_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
